// ----- design/sseq_pkg.sv -----
// Shared constants for the step sequencer with debounced inputs.
`default_nettype none

package sseq_pkg;

    localparam int FILTER_LENGTH = 4;
    localparam int FILT_LEN      = (FILTER_LENGTH < 1) ? 1 :
                                   (FILTER_LENGTH > 8) ? 8 : FILTER_LENGTH;

    localparam int NUM_LEVELS = 5;
    localparam int LVL_CLOCK  = 0;
    localparam int LVL_RESET  = 1;
    localparam int LVL_DIR    = 2;
    localparam int LVL_HALF   = 3;
    localparam int LVL_SOURCE = 4;

    localparam int STEP_W = 3;
    localparam int GATE_W = 8;
    localparam logic [STEP_W-1:0] LAST_FULL = 3'd7;
    localparam logic [STEP_W-1:0] LAST_HALF = 3'd3;

    typedef logic [STEP_W-1:0] step_t;
    typedef logic [NUM_LEVELS-1:0] levels_t;

endpackage

`default_nettype wire

// ----- design/step_sequencer_with_debounce.sv -----
// Top level: eight-step sequencer stepped by a debounced clock or a tick oscillator.
//
//  channel | signals                     | direction | beat
//  --------+-----------------------------+-----------+----------------------------
//  in      | in_valid/in_ready, raw_*,   | input     | one timer tick
//          | ticks_elapsed, beat_period  |           |
//  out     | out_valid/out_ready, step,  | output    | one result per tick
//          | gate and level fields       |           |
//
//  One beat per clock while not stalled: state and the result register update in the
//  accept cycle, and the result shows in the next cycle.
//  A held result stalls input only while out_ready is low (in_ready follows it).
//  Reset clears histories, levels, tick counter, step and the result valid flag.
`default_nettype none

module step_sequencer_with_debounce (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        raw_clock,
    input  wire logic        raw_reset,
    input  wire logic        raw_direction,
    input  wire logic        raw_half_length,
    input  wire logic        raw_internal_source,
    input  wire logic [7:0]  ticks_elapsed,
    input  wire logic [15:0] beat_period,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       step_index,
    output logic [7:0]       gate_onehot,
    output logic             beat_pulse,
    output logic             clock_edge,
    output logic             reset_level,
    output logic             direction_level,
    output logic             half_mode,
    output logic             internal_selected
);

    logic                 accept;
    sseq_pkg::levels_t    raw_lv;
    sseq_pkg::levels_t    lv_next;

    logic                 prev_clock_reg;
    logic [15:0]          tick_count_reg;
    logic [15:0]          tick_count_next;
    logic [15:0]          tick_sum;
    sseq_pkg::step_t      step_reg;
    sseq_pkg::step_t      step_next;
    sseq_pkg::step_t      last_step;
    logic [3:0]           moved;
    logic                 edge_det;
    logic                 beat;
    logic                 step_clk;

    logic                 out_valid_reg;
    sseq_pkg::step_t      step_out_reg;
    logic [7:0]           gate_reg;
    logic                 beat_reg;
    logic                 edge_reg;
    sseq_pkg::levels_t    lv_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign raw_lv[sseq_pkg::LVL_CLOCK]  = raw_clock;
    assign raw_lv[sseq_pkg::LVL_RESET]  = raw_reset;
    assign raw_lv[sseq_pkg::LVL_DIR]    = raw_direction;
    assign raw_lv[sseq_pkg::LVL_HALF]   = raw_half_length;
    assign raw_lv[sseq_pkg::LVL_SOURCE] = raw_internal_source;

    generate
        for (genvar g = 0; g < sseq_pkg::NUM_LEVELS; g++) begin : g_deb
            sseq_debounce u_deb (
                .clk        (clk),
                .rst_n      (rst_n),
                .en         (accept),
                .raw        (raw_lv[g]),
                .level_next (lv_next[g])
            );
        end
    endgenerate

    always_comb
    begin
        edge_det = lv_next[sseq_pkg::LVL_CLOCK] && !prev_clock_reg;

        tick_sum = tick_count_reg + {8'd0, ticks_elapsed};
        beat     = (tick_sum >= beat_period);
        tick_count_next = beat ? 16'd0 : tick_sum;

        step_clk  = lv_next[sseq_pkg::LVL_SOURCE] ? beat : edge_det;
        last_step = lv_next[sseq_pkg::LVL_HALF] ? sseq_pkg::LAST_HALF : sseq_pkg::LAST_FULL;

        if (!step_clk)
            moved = {1'b0, step_reg};
        else if (lv_next[sseq_pkg::LVL_DIR])
            moved = {1'b0, step_reg} - 4'd1;
        else
            moved = {1'b0, step_reg} + 4'd1;

        priority if (lv_next[sseq_pkg::LVL_RESET])
            step_next = lv_next[sseq_pkg::LVL_DIR] ? last_step : '0;
        else if (step_clk && lv_next[sseq_pkg::LVL_DIR] && step_reg == '0)
            step_next = last_step;
        else if (moved > {1'b0, last_step})
            step_next = '0;
        else
            step_next = moved[2:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_clock_reg <= 1'b0;
            tick_count_reg <= '0;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                prev_clock_reg <= lv_next[sseq_pkg::LVL_CLOCK];
                tick_count_reg <= tick_count_next;
                step_reg       <= step_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            step_out_reg <= step_next;
            gate_reg     <= 8'd1 << step_next;
            beat_reg     <= beat;
            edge_reg     <= edge_det;
            lv_reg       <= lv_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign step_index        = step_out_reg;
    assign gate_onehot       = gate_reg;
    assign beat_pulse        = beat_reg;
    assign clock_edge        = edge_reg;
    assign reset_level       = lv_reg[sseq_pkg::LVL_RESET];
    assign direction_level   = lv_reg[sseq_pkg::LVL_DIR];
    assign half_mode         = lv_reg[sseq_pkg::LVL_HALF];
    assign internal_selected = lv_reg[sseq_pkg::LVL_SOURCE];

endmodule

`default_nettype wire

// ----- design/sseq_debounce.sv -----
// Shift-register debouncer for one raw level, holding the last steady value.
`default_nettype none

module sseq_debounce (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire logic raw,
    output logic      level_next
);

    logic [sseq_pkg::FILT_LEN-1:0] hist_reg;
    logic [sseq_pkg::FILT_LEN-1:0] hist_next;
    logic                          level_reg;

    generate
        if (sseq_pkg::FILT_LEN > 1) begin : g_shift
            assign hist_next = {hist_reg[sseq_pkg::FILT_LEN-2:0], raw};
        end else begin : g_single
            assign hist_next = raw;
        end
    endgenerate

    always_comb
    begin
        priority if (hist_next == '0)
            level_next = 1'b0;
        else if (hist_next == '1)
            level_next = 1'b1;
        else
            level_next = level_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg  <= '0;
            level_reg <= 1'b0;
        end
        else if (en)
        begin
            hist_reg  <= hist_next;
            level_reg <= level_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/sseq_checker.sv -----
// Port-level checks for the step sequencer, bound to the top level.
`default_nettype none

module sseq_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [2:0]  step_index,
    input wire logic [7:0]  gate_onehot,
    input wire logic        reset_level,
    input wire logic        direction_level,
    input wire logic        half_mode
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted beat gave no result");

    a_gate_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> gate_onehot == (8'd1 << step_index))
        else $error("gate does not match step");

    a_half_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && half_mode |-> !step_index[2])
        else $error("step beyond half length");

    a_reset_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reset_level && !direction_level |-> step_index == 3'd0)
        else $error("reset forward did not give first step");

endmodule

bind step_sequencer_with_debounce sseq_checker u_sseq_checker (.*);

`default_nettype wire
